FILE: design/kvlt_pkg.sv
// Shared types, token codes and character constants for the key/value line tokenizer.
package kvlt_pkg;

    // Parser phase, one-hot
    typedef enum logic [6:0] {
        PH_START      = 7'b0000001,
        PH_COMMENT    = 7'b0000010,
        PH_KEY        = 7'b0000100,
        PH_KEY_TRAIL  = 7'b0001000,
        PH_VALUE_LEAD = 7'b0010000,
        PH_VALUE      = 7'b0100000,
        PH_ERROR      = 7'b1000000
    } phase_t;

    // Token kinds on the result stream
    typedef enum logic [2:0] {
        TK_KEY   = 3'd0,
        TK_VALUE = 3'd1,
        TK_PAIR  = 3'd2,
        TK_ERROR = 3'd3,
        TK_END   = 3'd4
    } tok_kind_t;

    // Characters the parser reacts to
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // One result word
    typedef struct packed {
        tok_kind_t          kind;
        logic [7:0]         tok_byte;
        logic signed [31:0] key_hash;
        logic               last;
    } result_t;

    // Results produced by one input byte, handed to the queue
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic result_t make_result(tok_kind_t k, logic [7:0] b, logic [31:0] h);
        result_t r;
        r.kind     = k;
        r.tok_byte = b;
        r.key_hash = h;
        r.last     = 1'b0;
        return r;
    endfunction

endpackage

FILE: design/key_value_line_tokenizer.sv
// Top level of the key/value line tokenizer.
// Takes one text byte per word on the slave side and issues key-byte, value-byte, pair-end,
// error and end-of-text tokens on the master side, up to two tokens per text byte, with
// tlast on the final token of each byte. A byte is taken every cycle while the four-word
// result queue has space for two more words. Each byte is held in the input register, where
// its tokens are decoded, and they enter the queue when it has room; the sink is offered
// them from the queue. Sustained rate is one byte per cycle when each byte gives at most
// one token and the sink is always ready; the single output port of the queue sets the
// limit of one token per cycle.
module key_value_line_tokenizer
    import kvlt_pkg::*;
#(
    parameter int KEY_MAX   = 64,
    parameter int VALUE_MAX = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] token_byte, [39:8] key_hash
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast    // last_of_run
);

    push_t   push;
    logic    room;
    result_t out_word;

    kvlt_parser #(
        .KEY_MAX   (KEY_MAX),
        .VALUE_MAX (VALUE_MAX)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .room     (room),
        .push     (push)
    );

    kvlt_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_word)
    );

    // Output word packing
    assign m_tdata = {out_word.key_hash, out_word.tok_byte};
    assign m_tuser = out_word.kind;
    assign m_tlast = out_word.last;

endmodule

FILE: design/kvlt_parser.sv
// Input register, parse state and per-byte token decode.
module kvlt_parser
    import kvlt_pkg::*;
#(
    parameter int KEY_MAX   = 64,
    parameter int VALUE_MAX = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       room,      // queue can take two words
    output push_t      push
);

    localparam int KEY_W = $clog2(KEY_MAX + 1);
    localparam int VAL_W = $clog2(VALUE_MAX + 1);
    localparam logic [KEY_W-1:0] KEY_LIMIT = KEY_W'(KEY_MAX);
    localparam logic [VAL_W-1:0] VAL_LIMIT = VAL_W'(VALUE_MAX);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    phase_t           phase_reg, phase_next;
    logic [KEY_W-1:0] klen_reg, klen_next;
    logic [VAL_W-1:0] vlen_reg, vlen_next;
    logic [31:0]      hash_reg, hash_next;

    logic       fire;
    logic       brk;
    logic [7:0] c;
    logic [1:0] n;
    result_t    r0, r1;

    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || fire;
    assign c        = in_byte_reg;
    assign brk      = (c == CH_LF) || (c == CH_CR);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // Token decode and next state
    always_comb
    begin
        phase_next = phase_reg;
        klen_next  = klen_reg;
        vlen_next  = vlen_reg;
        hash_next  = hash_reg;
        n          = 2'd0;
        r0         = make_result(TK_END, 8'h00, 32'h0);
        r1         = make_result(TK_END, 8'h00, 32'h0);

        case (phase_reg)
            PH_COMMENT, PH_ERROR:
            begin
                if (brk)
                begin
                    phase_next = PH_START;
                    klen_next  = '0;
                    vlen_next  = '0;
                end
                else if (c == CH_NUL)
                begin
                    n          = 2'd1;
                    phase_next = PH_START;
                    klen_next  = '0;
                    vlen_next  = '0;
                end
            end

            PH_KEY, PH_KEY_TRAIL:
            begin
                if (c == CH_SPACE)
                begin
                    phase_next = PH_KEY_TRAIL;
                end
                else if (c == CH_EQ)
                begin
                    phase_next = PH_VALUE_LEAD;
                    vlen_next  = '0;
                end
                else if (brk)
                begin
                    n          = 2'd1;
                    r0         = make_result(TK_ERROR, 8'h00, 32'h0);
                    phase_next = PH_START;
                    klen_next  = '0;
                    vlen_next  = '0;
                end
                else if (c == CH_NUL)
                begin
                    n          = 2'd2;
                    r0         = make_result(TK_ERROR, 8'h00, 32'h0);
                    phase_next = PH_START;
                    klen_next  = '0;
                    vlen_next  = '0;
                end
                else if (phase_reg == PH_KEY_TRAIL || klen_reg >= KEY_LIMIT)
                begin
                    n          = 2'd1;
                    r0         = make_result(TK_ERROR, 8'h00, 32'h0);
                    phase_next = PH_ERROR;
                end
                else
                begin
                    // h*31 + c as a shift and subtract
                    n         = 2'd1;
                    r0        = make_result(TK_KEY, c, 32'h0);
                    hash_next = (hash_reg << 5) - hash_reg + {24'h0, c};
                    klen_next = klen_reg + KEY_W'(1);
                end
            end

            PH_VALUE_LEAD, PH_VALUE:
            begin
                if (brk || c == CH_HASH)
                begin
                    n          = 2'd1;
                    r0         = make_result(TK_PAIR, 8'h00, hash_reg);
                    phase_next = brk ? PH_START : PH_COMMENT;
                    klen_next  = '0;
                    vlen_next  = '0;
                end
                else if (c == CH_NUL)
                begin
                    n          = 2'd2;
                    r0         = make_result(TK_PAIR, 8'h00, hash_reg);
                    phase_next = PH_START;
                    klen_next  = '0;
                    vlen_next  = '0;
                end
                else if (phase_reg == PH_VALUE_LEAD && c == CH_SPACE)
                begin
                    // leading blank of a value is dropped
                end
                else if (phase_reg == PH_VALUE && vlen_reg >= VAL_LIMIT)
                begin
                    // full chunk: close it and start another for the same key
                    r0 = make_result(TK_PAIR, 8'h00, hash_reg);
                    if (c == CH_SPACE)
                    begin
                        n          = 2'd1;
                        vlen_next  = '0;
                        phase_next = PH_VALUE_LEAD;
                    end
                    else
                    begin
                        n          = 2'd2;
                        r1         = make_result(TK_VALUE, c, 32'h0);
                        vlen_next  = VAL_W'(1);
                        phase_next = PH_VALUE;
                    end
                end
                else
                begin
                    n          = 2'd1;
                    r0         = make_result(TK_VALUE, c, 32'h0);
                    vlen_next  = vlen_reg + VAL_W'(1);
                    phase_next = PH_VALUE;
                end
            end

            default:
            begin
                // line start, and any code outside the one-hot set
                klen_next  = '0;
                vlen_next  = '0;
                phase_next = PH_START;
                if (c == CH_SPACE || brk)
                begin
                end
                else if (c == CH_HASH)
                begin
                    phase_next = PH_COMMENT;
                end
                else if (c == CH_EQ)
                begin
                    n          = 2'd1;
                    r0         = make_result(TK_ERROR, 8'h00, 32'h0);
                    phase_next = PH_ERROR;
                end
                else if (c == CH_NUL)
                begin
                    n = 2'd1;
                end
                else
                begin
                    n          = 2'd1;
                    r0         = make_result(TK_KEY, c, 32'h0);
                    hash_next  = {24'h0, c};
                    klen_next  = KEY_W'(1);
                    phase_next = PH_KEY;
                end
            end
        endcase

        // mark the final word of this byte
        r0.last = (n == 2'd1);
        r1.last = 1'b1;
    end

    always_comb
    begin
        push.count = fire ? n : 2'd0;
        push.r0    = r0;
        push.r1    = r1;
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            klen_reg  <= '0;
            vlen_reg  <= '0;
            hash_reg  <= 32'h0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            klen_reg  <= klen_next;
            vlen_reg  <= vlen_next;
            hash_reg  <= hash_next;
        end
    end

endmodule

FILE: design/kvlt_out_fifo.sv
// Small result queue taking up to two words per cycle and giving one while the reader is ready.
module kvlt_out_fifo
    import kvlt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg;
    logic                 pop;
    logic [FIFO_AW-1:0]   wr_ptr_1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_word  = mem[rd_ptr_reg];
    assign room      = (FIFO_CW'(FIFO_DEPTH) - count_reg) >= FIFO_CW'(2);
    assign wr_ptr_1  = wr_ptr_reg + FIFO_AW'(1);

    // Storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_1] <= push.r1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push.count);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + FIFO_CW'(push.count) - FIFO_CW'(pop);
        end
    end

endmodule

FILE: tb/key_value_line_tokenizer_test.sv
// Testbench for the key/value line tokenizer: directed and random text checked against a predictor.
module key_value_line_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kvlt_pkg::*;

    localparam int KEY_LIMIT    = 64;
    localparam int VALUE_LIMIT  = 256;
    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 5;
    localparam int HOLD_CYCLES  = 150;   // long sink stall in the back-pressure test
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES = 16;
    localparam int REPORT_LINES = 40;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Stimulus control
    bit idle_enabled = 1'b1;
    bit hold_sink    = 1'b0;
    int bytes_sent   = 0;

    // Predictor state
    phase_t      parse_state  = PH_START;
    logic [6:0]  key_count    = '0;
    logic [8:0]  value_count  = '0;
    logic [31:0] key_hash_acc = '0;
    int          tokens_this_byte;
    result_t     expected_tokens[$];

    // Checking
    result_t next_token;
    int      tokens_seen    = 0;
    int      mismatch_count = 0;
    int      stall_cycles   = 0;

    logic [7:0] skip_chars[3] = '{CH_SPACE, CH_LF, CH_CR};

    key_value_line_tokenizer #(
        .KEY_MAX   (KEY_LIMIT),
        .VALUE_MAX (VALUE_LIMIT)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic bit is_line_break(logic [7:0] c);
        return c == CH_LF || c == CH_CR;
    endfunction

    task automatic emit(input tok_kind_t kind, input logic [7:0] b, input logic [31:0] h);
        result_t t;
        t.kind     = kind;
        t.tok_byte = b;
        t.key_hash = h;
        t.last     = 1'b0;
        expected_tokens.push_back(t);
        tokens_this_byte++;
    endtask

    task automatic restart_line();
        parse_state = PH_START;
        key_count   = '0;
        value_count = '0;
    endtask

    // Works out the tokens caused by one accepted text byte
    task automatic predict_tokens(input logic [7:0] c);
        tokens_this_byte = 0;
        case (parse_state)
            PH_COMMENT, PH_ERROR:
            begin
                if (is_line_break(c))
                    restart_line();
                else if (c == CH_NUL)
                begin
                    emit(TK_END, 8'h00, 32'h0);
                    restart_line();
                end
            end
            PH_KEY, PH_KEY_TRAIL:
            begin
                if (c == CH_SPACE)
                    parse_state = PH_KEY_TRAIL;
                else if (c == CH_EQ)
                begin
                    parse_state = PH_VALUE_LEAD;
                    value_count = '0;
                end
                else if (is_line_break(c))
                begin
                    emit(TK_ERROR, 8'h00, 32'h0);
                    restart_line();
                end
                else if (c == CH_NUL)
                begin
                    emit(TK_ERROR, 8'h00, 32'h0);
                    emit(TK_END, 8'h00, 32'h0);
                    restart_line();
                end
                else if (parse_state == PH_KEY_TRAIL || key_count >= KEY_LIMIT)
                begin
                    // junk after the key, or key over length
                    emit(TK_ERROR, 8'h00, 32'h0);
                    parse_state = PH_ERROR;
                end
                else
                begin
                    emit(TK_KEY, c, 32'h0);
                    key_hash_acc = key_hash_acc * 32'd31 + {24'd0, c};
                    key_count    = key_count + 7'd1;
                end
            end
            PH_VALUE_LEAD, PH_VALUE:
            begin
                if (is_line_break(c))
                begin
                    emit(TK_PAIR, 8'h00, key_hash_acc);
                    restart_line();
                end
                else if (c == CH_HASH)
                begin
                    emit(TK_PAIR, 8'h00, key_hash_acc);
                    restart_line();
                    parse_state = PH_COMMENT;
                end
                else if (c == CH_NUL)
                begin
                    emit(TK_PAIR, 8'h00, key_hash_acc);
                    emit(TK_END, 8'h00, 32'h0);
                    restart_line();
                end
                else if (parse_state == PH_VALUE_LEAD && c == CH_SPACE)
                begin
                    // leading blank of a value: dropped
                end
                else if (parse_state == PH_VALUE && value_count >= VALUE_LIMIT)
                begin
                    // chunk full: close it and open the next one for the same key
                    emit(TK_PAIR, 8'h00, key_hash_acc);
                    value_count = '0;
                    if (c == CH_SPACE)
                        parse_state = PH_VALUE_LEAD;
                    else
                    begin
                        emit(TK_VALUE, c, 32'h0);
                        value_count = 9'd1;
                        parse_state = PH_VALUE;
                    end
                end
                else
                begin
                    emit(TK_VALUE, c, 32'h0);
                    value_count = value_count + 9'd1;
                    parse_state = PH_VALUE;
                end
            end
            default:
            begin
                if (c == CH_SPACE || is_line_break(c))
                    restart_line();
                else if (c == CH_HASH)
                begin
                    restart_line();
                    parse_state = PH_COMMENT;
                end
                else if (c == CH_EQ)
                begin
                    emit(TK_ERROR, 8'h00, 32'h0);
                    restart_line();
                    parse_state = PH_ERROR;
                end
                else if (c == CH_NUL)
                begin
                    emit(TK_END, 8'h00, 32'h0);
                    restart_line();
                end
                else
                begin
                    emit(TK_KEY, c, 32'h0);
                    key_hash_acc = {24'd0, c};
                    key_count    = 7'd1;
                    value_count  = '0;
                    parse_state  = PH_KEY;
                end
            end
        endcase
        if (tokens_this_byte > 0)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    // ---------------------------------------------------------------- driving

    // Offers one text byte and waits until the word is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (idle_enabled && $urandom_range(99) < 3)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_tokens(b);
        bytes_sent++;
    endtask

    function automatic logic [7:0] rand_key_byte(input bit first);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_EQ || is_line_break(c) || (first && c == CH_HASH));
        return c;
    endfunction

    function automatic logic [7:0] rand_value_byte(input bit blank_ok);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_line_break(c) || c == CH_HASH || (!blank_ok && c == CH_SPACE));
        return c;
    endfunction

    function automatic logic [7:0] rand_comment_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (is_line_break(c));
        return c;
    endfunction

    function automatic logic [7:0] pick_terminator();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return CH_LF;
        else if (r < 65)
            return CH_CR;
        else if (r < 85)
            return CH_HASH;
        else
            return CH_NUL;
    endfunction

    task automatic send_key_bytes(input int len);
        for (int i = 0; i < len; i++)
            send_byte(rand_key_byte(i == 0));
    endtask

    // Optional blank lines, the key, blanks around '='
    task automatic send_key_part(input int len);
        repeat ($urandom_range(0, 2)) send_byte(skip_chars[$urandom_range(2)]);
        send_key_bytes(len);
        repeat ($urandom_range(0, 2)) send_byte(CH_SPACE);
        send_byte(CH_EQ);
        repeat ($urandom_range(0, 2)) send_byte(CH_SPACE);
    endtask

    task automatic send_value_part(input int len, input bit blank_ok);
        for (int i = 0; i < len; i++)
            send_byte(rand_value_byte(blank_ok));
    endtask

    // Terminator; a '#' opens a trailing comment closed by a break
    task automatic end_line(input logic [7:0] term);
        send_byte(term);
        if (term == CH_HASH)
        begin
            repeat ($urandom_range(0, 5)) send_byte(rand_comment_byte());
            send_byte($urandom_range(1) ? CH_LF : CH_CR);
        end
    endtask

    // One line of text, mostly well formed, the rest broken lines and noise
    task automatic send_random_line();
        int pick;
        int tail;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            send_key_part($urandom_range(1, 10));
            send_value_part($urandom_range(0, 12), 1'b1);
            end_line(pick_terminator());
        end
        else if (pick < 65)
        begin
            send_byte(CH_HASH);
            repeat ($urandom_range(0, 8)) send_byte(rand_comment_byte());
            end_line(pick_terminator());
        end
        else if (pick < 73)
        begin
            send_byte(CH_EQ);
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(255)));
            end_line(pick_terminator());
        end
        else if (pick < 81)
        begin
            // key with no '='
            send_key_bytes($urandom_range(1, 6));
            tail = $urandom_range(2);
            if (tail == 0)
                end_line($urandom_range(1) ? CH_LF : CH_CR);
            else if (tail == 1)
                send_byte(CH_NUL);
            else
            begin
                repeat ($urandom_range(0, 2)) send_byte(CH_SPACE);
                send_byte(rand_key_byte(1'b0));
                repeat ($urandom_range(0, 3)) send_byte(rand_comment_byte());
                send_byte(CH_LF);
            end
        end
        else if (pick < 85)
        begin
            send_key_part($urandom_range(KEY_LIMIT + 1, KEY_LIMIT + 4));
            send_value_part($urandom_range(0, 4), 1'b1);
            send_byte(CH_LF);
        end
        else
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
    endtask

    task automatic run_random_text(input int count);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < count)
            send_random_line();
    endtask

    // ---------------------------------------------------------------- tests

    // Field extremes, every token kind, the error lines and end of text
    task automatic test_directed();
        logic [7:0] script[24];
        script = '{CH_NUL,
                   CH_SPACE, CH_LF,
                   CH_HASH, 8'h21, CH_CR,
                   CH_EQ, CH_LF,
                   8'hFF, CH_SPACE, CH_EQ, 8'hFE, CH_LF,
                   "a", CH_SPACE, "b", CH_LF,
                   "k", CH_EQ, "v", CH_HASH, CH_LF,
                   "q", CH_NUL};
        foreach (script[i])
            send_byte(script[i]);
    endtask

    // Key exactly at the limit, then one byte over
    task automatic test_long_keys();
        send_key_part(KEY_LIMIT);
        send_value_part(2, 1'b1);
        end_line(CH_LF);
        send_key_part(KEY_LIMIT + 1);
        send_value_part(2, 1'b1);
        end_line(CH_LF);
    endtask

    // Values around the chunk boundary
    task automatic test_long_values();
        // exactly full: a single pair end
        send_key_part(2);
        send_value_part(VALUE_LIMIT, 1'b0);
        send_byte(CH_LF);
        // full, then a blank: pair end, then an empty chunk closed by the break
        send_key_part(2);
        send_value_part(VALUE_LIMIT, 1'b0);
        send_byte(CH_SPACE);
        send_byte(CH_CR);
        // one byte over: the byte opens the next chunk
        send_key_part(2);
        send_value_part(VALUE_LIMIT + 1, 1'b0);
        send_value_part(3, 1'b1);
        end_line(CH_NUL);
    endtask

    // Sink stalls for a long stretch while text keeps coming
    task automatic test_back_pressure();
        hold_sink = 1'b1;
        repeat (4)
        begin
            send_key_part($urandom_range(2, 6));
            send_value_part($urandom_range(4, 10), 1'b1);
            end_line(CH_LF);
        end
    endtask

    task automatic test_no_idle();
        idle_enabled = 1'b0;
        run_random_text(250);
        idle_enabled = 1'b1;
    endtask

    task automatic test_random_text();
        run_random_text(450);
    endtask

    // ---------------------------------------------------------------- sink and checks

    // Sink ready: random idling, plus the long hold on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_sink = 1'b0;
            end
            m_tready <= !(idle_enabled && $urandom_range(99) < 10);
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("token %0d: %s is %h, predicted %h", tokens_seen, field, got, want);
    endtask

    // Compare each token word with the oldest prediction
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            tokens_seen++;
            if (expected_tokens.size() == 0)
                report_mismatch("unpredicted token kind", {29'd0, m_tuser}, 32'h0);
            else
            begin
                next_token = expected_tokens.pop_front();
                if (m_tuser !== next_token.kind)
                    report_mismatch("kind", {29'd0, m_tuser}, {29'd0, next_token.kind});
                if (m_tdata[7:0] !== next_token.tok_byte)
                    report_mismatch("byte", {24'd0, m_tdata[7:0]}, {24'd0, next_token.tok_byte});
                if (m_tdata[39:8] !== next_token.key_hash)
                    report_mismatch("hash", m_tdata[39:8], next_token.key_hash);
                if (m_tlast !== next_token.last)
                    report_mismatch("last", {31'd0, m_tlast}, {31'd0, next_token.last});
            end
        end
    end

    // Watchdog: nothing moving on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_long_keys();
        test_long_values();
        test_back_pressure();
        test_no_idle();
        test_random_text();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: key_value_line_tokenizer.f
design/kvlt_pkg.sv
design/kvlt_parser.sv
design/kvlt_out_fifo.sv
design/key_value_line_tokenizer.sv
tb/key_value_line_tokenizer_test.sv
